[rtl/rmpp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the rotated mono pixel plotter.
// No dependencies; used by every module of the block.
package rmpp_pkg;

   // Field widths
   localparam int COORD_W     = 16;
   localparam int DIM_W       = 12;
   localparam int ROWB_W      = 9;
   localparam int STEP_W      = 8;
   localparam int ROT_W       = 2;
   localparam int ACTION_W    = 2;
   localparam int ADDR_W      = 13;
   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;
   // Width of row * row_bytes + column byte before the store bound check
   localparam int ADDR_CALC_W = DIM_W + ROWB_W + 1;

   localparam int STORE_BYTES_DEFAULT = 8192;

   // Most significant pixel of a byte sits at column zero
   localparam logic [BYTE_W-1:0] PIXEL_MSB = 8'h80;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_ROTATED  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ABSOLUTE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ     = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_READ_ALT = 2'd3;

   // Rotation codes
   localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
   localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
   localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
   localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PANEL_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PANEL_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_BYTES    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ROTATION     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_EN    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_STEP  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_COUNT = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_DRAW_COLOR   = 3'd7;

   typedef struct packed {
      logic [DIM_W-1:0]  panel_width;
      logic [DIM_W-1:0]  panel_height;
      logic [ROWB_W-1:0] row_bytes;
      logic [ROT_W-1:0]  rotation;
      logic              offset_enable;
      logic [STEP_W-1:0] offset_step;
      logic [STEP_W-1:0] offset_step_count;
      logic              draw_color;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      panel_width:       12'd200,
      panel_height:      12'd200,
      row_bytes:         9'd25,
      rotation:          ROT_0,
      offset_enable:     1'b0,
      offset_step:       8'd0,
      offset_step_count: 8'd1,
      draw_color:        1'b0
   };

   // Resolved plot target handed from the coordinate unit to the top level
   typedef struct packed {
      logic              ok;
      logic              is_read;
      logic [ADDR_W-1:0] byte_address;
      logic [BYTE_W-1:0] mask;
   } plot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BAND,
      ST_MAP,
      ST_ADDR,
      ST_READ,
      ST_COMMIT
   } state_type;

endpackage

[rtl/rmpp_store.sv]
`timescale 1ns / 1ps
// Frame store: one-byte-wide synchronous RAM with registered read and a
// zeroing sweep after reset. Depends on rmpp_pkg.
module rmpp_store #(
   parameter int STORE_BYTES = rmpp_pkg::STORE_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   output logic                            clear_busy,
   input  logic [$clog2(STORE_BYTES)-1:0]  rd_addr,
   output logic [rmpp_pkg::BYTE_W-1:0]     rd_data,
   input  logic                            wr_en,
   input  logic [$clog2(STORE_BYTES)-1:0]  wr_addr,
   input  logic [rmpp_pkg::BYTE_W-1:0]     wr_data
);

   localparam int AW = $clog2(STORE_BYTES);
   localparam int CW = $clog2(STORE_BYTES + 1);

   logic [rmpp_pkg::BYTE_W-1:0] mem [STORE_BYTES];
   logic [CW-1:0]               clr_ff;
   logic [CW-1:0]               clr_in;
   logic [rmpp_pkg::BYTE_W-1:0] rd_data_ff;

   // Sweep counter runs once through the store after reset
   assign clear_busy = (clr_ff != CW'(STORE_BYTES));
   assign clr_in     = clear_busy ? clr_ff + CW'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // Zero during the sweep, otherwise take the plot write; read every cycle
   always_ff @(posedge clock) begin
      if (clear_busy) begin
         mem[clr_ff[AW-1:0]] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rmpp_xform.sv]
`timescale 1ns / 1ps
// Coordinate unit: band offset, clipping, rotation map and byte address,
// three register stages fed by the held request. Depends on rmpp_pkg.
module rmpp_xform #(
   parameter int STORE_BYTES = rmpp_pkg::STORE_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  rmpp_pkg::cfg_type                 cfg,
   input  logic [rmpp_pkg::ACTION_W-1:0]     action,
   input  logic [rmpp_pkg::COORD_W-1:0]      x_coord,
   input  logic [rmpp_pkg::COORD_W-1:0]      y_coord,
   input  logic [rmpp_pkg::ADDR_W-1:0]       read_address,
   output rmpp_pkg::plot_type                plot,
   output logic [$clog2(STORE_BYTES)-1:0]    mem_addr
);

   localparam int AW     = $clog2(STORE_BYTES);
   localparam int CW     = rmpp_pkg::COORD_W;
   localparam int DW     = rmpp_pkg::DIM_W;
   localparam int PW     = rmpp_pkg::DIM_W + rmpp_pkg::COORD_W;
   localparam int ACW    = rmpp_pkg::ADDR_CALC_W;
   localparam int MULW   = rmpp_pkg::DIM_W + rmpp_pkg::ROWB_W;

   // Stage 1: band offset
   logic [CW-1:0] band_k;
   logic [PW-1:0] band_prod;
   logic [CW-1:0] band_ff;
   logic [CW-1:0] band_in;

   // Stage 2: clip and rotate
   logic          rot_odd;
   logic [CW-1:0] xo;
   logic [CW-1:0] yo;
   logic [CW-1:0] pw16;
   logic [CW-1:0] ph16;
   logic          hit_in;
   logic [DW-1:0] px_in;
   logic [DW-1:0] py_in;
   logic          hit_ff;
   logic [DW-1:0] px_ff;
   logic [DW-1:0] py_ff;

   // Stage 3: byte address and store bound
   logic [MULW-1:0]    row_prod;
   logic [ACW-1:0]     calc_addr;
   logic [ACW-1:0]     sel_addr;
   logic               is_read;
   rmpp_pkg::plot_type plot_in;
   rmpp_pkg::plot_type plot_ff;
   logic [AW-1:0]      mem_addr_ff;

   // Band index counts down for the 180 and 270 degree rotations
   always_comb begin
      if (cfg.rotation[1]) begin
         band_k = CW'(cfg.offset_step_count) - CW'(cfg.offset_step) - CW'(1);
      end else begin
         band_k = CW'(cfg.offset_step);
      end
      band_prod = PW'(cfg.panel_height) * PW'(band_k);
      band_in   = band_prod[CW-1:0];
   end

   // Subtract the band, clip against rotated bounds, map to the panel; absolute requests skip band and rotation
   always_comb begin
      rot_odd = (cfg.rotation == rmpp_pkg::ROT_90) || (cfg.rotation == rmpp_pkg::ROT_270);
      pw16    = CW'(cfg.panel_width);
      ph16    = CW'(cfg.panel_height);
      xo      = (cfg.offset_enable && rot_odd) ? x_coord - band_ff : x_coord;
      yo      = (cfg.offset_enable && !rot_odd) ? y_coord - band_ff : y_coord;
      if (action == rmpp_pkg::ACT_ABSOLUTE) begin
         hit_in = (x_coord < pw16) && (y_coord < ph16);
         px_in  = x_coord[DW-1:0];
         py_in  = y_coord[DW-1:0];
      end else begin
         if (rot_odd) begin
            hit_in = (xo < ph16) && (yo < pw16);
         end else begin
            hit_in = (xo < pw16) && (yo < ph16);
         end
         case (cfg.rotation)
            rmpp_pkg::ROT_0: begin
               px_in = xo[DW-1:0];
               py_in = yo[DW-1:0];
            end
            rmpp_pkg::ROT_90: begin
               px_in = cfg.panel_width - yo[DW-1:0] - DW'(1);
               py_in = xo[DW-1:0];
            end
            rmpp_pkg::ROT_180: begin
               px_in = cfg.panel_width - xo[DW-1:0] - DW'(1);
               py_in = cfg.panel_height - yo[DW-1:0] - DW'(1);
            end
            default: begin
               px_in = yo[DW-1:0];
               py_in = cfg.panel_height - xo[DW-1:0] - DW'(1);
            end
         endcase
      end
   end

   // Form the byte address and check it against the store size
   always_comb begin
      is_read   = (action == rmpp_pkg::ACT_READ) || (action == rmpp_pkg::ACT_READ_ALT);
      row_prod  = MULW'(py_ff) * MULW'(cfg.row_bytes);
      calc_addr = ACW'(row_prod) + ACW'(px_ff[DW-1:3]);
      sel_addr  = is_read ? ACW'(read_address) : calc_addr;
      plot_in.ok           = (sel_addr < ACW'(STORE_BYTES)) && (is_read || hit_ff);
      plot_in.is_read      = is_read;
      plot_in.byte_address = sel_addr[rmpp_pkg::ADDR_W-1:0];
      plot_in.mask         = rmpp_pkg::PIXEL_MSB >> px_ff[2:0];
   end

   always_ff @(posedge clock) begin
      band_ff     <= band_in;
      hit_ff      <= hit_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      plot_ff     <= plot_in;
      mem_addr_ff <= sel_addr[AW-1:0];
   end

   assign plot     = plot_ff;
   assign mem_addr = mem_addr_ff;

endmodule

[rtl/rotated_mono_pixel_plotter.sv]
`timescale 1ns / 1ps
// Each transaction passes band, map and address registers, then one store
// read before the write-back; req_stall stays high until it commits, so a new
// transaction is taken only once the previous one is done.
// Reset: configuration returns to defaults and the frame store is zeroed by a
// sweep through all STORE_BYTES bytes, during which req_stall stays high.
module rotated_mono_pixel_plotter #(
   parameter int STORE_BYTES = rmpp_pkg::STORE_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rmpp_pkg::ACTION_W-1:0]      req_action,
   input  logic [rmpp_pkg::COORD_W-1:0]       req_x_coord,
   input  logic [rmpp_pkg::COORD_W-1:0]       req_y_coord,
   input  logic                               req_pen_white,
   input  logic                               req_use_default_pen,
   input  logic [rmpp_pkg::ADDR_W-1:0]        req_read_address,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_wrote,
   output logic [rmpp_pkg::ADDR_W-1:0]        rsp_byte_address,
   output logic [rmpp_pkg::BYTE_W-1:0]        rsp_byte_value,
   input  logic                               csr_write,
   input  logic [rmpp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rmpp_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int AW = $clog2(STORE_BYTES);

   rmpp_pkg::cfg_type   cfg_ff;
   rmpp_pkg::state_type state_ff;
   rmpp_pkg::state_type state_in;

   logic [rmpp_pkg::ACTION_W-1:0] action_ff;
   logic [rmpp_pkg::COORD_W-1:0]  x_ff;
   logic [rmpp_pkg::COORD_W-1:0]  y_ff;
   logic                          pen_ff;
   logic                          use_default_ff;
   logic [rmpp_pkg::ADDR_W-1:0]   read_address_ff;

   rmpp_pkg::plot_type          plot;
   logic [AW-1:0]               mem_addr;
   logic [rmpp_pkg::BYTE_W-1:0] rd_data;
   logic [rmpp_pkg::BYTE_W-1:0] new_byte;
   logic                        clear_busy;
   logic                        white;
   logic                        accept;
   logic                        out_free;
   logic                        commit;
   logic                        store_we;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          rsp_wrote_ff;
   logic [rmpp_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic [rmpp_pkg::BYTE_W-1:0]   rsp_value_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= rmpp_pkg::CFG_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            rmpp_pkg::REG_PANEL_WIDTH:  cfg_ff.panel_width  <= csr_data[rmpp_pkg::DIM_W-1:0];
            rmpp_pkg::REG_PANEL_HEIGHT: cfg_ff.panel_height <= csr_data[rmpp_pkg::DIM_W-1:0];
            rmpp_pkg::REG_ROW_BYTES:    cfg_ff.row_bytes    <= csr_data[rmpp_pkg::ROWB_W-1:0];
            rmpp_pkg::REG_ROTATION:     cfg_ff.rotation     <= csr_data[rmpp_pkg::ROT_W-1:0];
            rmpp_pkg::REG_OFFSET_EN:    cfg_ff.offset_enable <= csr_data[0];
            rmpp_pkg::REG_OFFSET_STEP:  cfg_ff.offset_step  <= csr_data[rmpp_pkg::STEP_W-1:0];
            rmpp_pkg::REG_OFFSET_COUNT: begin
               cfg_ff.offset_step_count <= csr_data[rmpp_pkg::STEP_W-1:0];
            end
            rmpp_pkg::REG_DRAW_COLOR:   cfg_ff.draw_color   <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != rmpp_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == rmpp_pkg::ST_COMMIT) && out_free;

   // Hold the request fields for the whole pass
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff       <= req_action;
         x_ff            <= req_x_coord;
         y_ff            <= req_y_coord;
         pen_ff          <= req_pen_white;
         use_default_ff  <= req_use_default_pen;
         read_address_ff <= req_read_address;
      end
   end

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmpp_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance one stage per cycle; wait in commit while the result is held
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmpp_pkg::ST_CLEAR:  if (!clear_busy) state_in = rmpp_pkg::ST_IDLE;
         rmpp_pkg::ST_IDLE:   if (accept) state_in = rmpp_pkg::ST_BAND;
         rmpp_pkg::ST_BAND:   state_in = rmpp_pkg::ST_MAP;
         rmpp_pkg::ST_MAP:    state_in = rmpp_pkg::ST_ADDR;
         rmpp_pkg::ST_ADDR:   state_in = rmpp_pkg::ST_READ;
         rmpp_pkg::ST_READ:   state_in = rmpp_pkg::ST_COMMIT;
         rmpp_pkg::ST_COMMIT: if (out_free) state_in = rmpp_pkg::ST_IDLE;
         default:             state_in = rmpp_pkg::ST_IDLE;
      endcase
   end

   rmpp_xform #(
      .STORE_BYTES (STORE_BYTES)
   ) u_xform (
      .clock        (clock),
      .cfg          (cfg_ff),
      .action       (action_ff),
      .x_coord      (x_ff),
      .y_coord      (y_ff),
      .read_address (read_address_ff),
      .plot         (plot),
      .mem_addr     (mem_addr)
   );

   // Modify the fetched byte
   assign white    = use_default_ff ? cfg_ff.draw_color : pen_ff;
   assign new_byte = white ? (rd_data | plot.mask) : (rd_data & ~plot.mask);
   assign store_we = commit && plot.ok && !plot.is_read;

   rmpp_store #(
      .STORE_BYTES (STORE_BYTES)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .rd_addr    (mem_addr),
      .rd_data    (rd_data),
      .wr_en      (store_we),
      .wr_addr    (mem_addr),
      .wr_data    (new_byte)
   );

   // Output register: load on commit, drop once taken
   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_wrote_ff <= plot.ok && !plot.is_read;
         rsp_addr_ff  <= (plot.ok || plot.is_read) ? plot.byte_address : '0;
         if (!plot.ok) begin
            rsp_value_ff <= '0;
         end else if (plot.is_read) begin
            rsp_value_ff <= rd_data;
         end else begin
            rsp_value_ff <= new_byte;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_wrote        = rsp_wrote_ff;
   assign rsp_byte_address = rsp_addr_ff;
   assign rsp_byte_value   = rsp_value_ff;

   // A new result appears only out of the commit step
   a_result_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == rmpp_pkg::ST_COMMIT))
      else $error("result raised outside commit");

   // No transaction is taken while the store is being zeroed
   a_stall_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmpp_pkg::ST_CLEAR) |-> req_stall)
      else $error("request taken during store clear");

   // Every store write is reported as a written byte
   a_write_reported: assert property (@(posedge clock) disable iff (reset)
      store_we |=> (rsp_valid && rsp_wrote))
      else $error("store write without written result");

   // The store is never written outside the commit step
   a_write_in_commit: assert property (@(posedge clock) disable iff (reset)
      store_we |-> (state_ff == rmpp_pkg::ST_COMMIT) && !clear_busy)
      else $error("store write outside commit");

endmodule
